### rtl/mbbs_pkg.sv
package mbbs_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_W = 32;
    localparam int VTX_W = 3 * COORD_W;
    localparam int SQ_W = 64;
    localparam int ROOT_W = 32;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BOX,
        ST_SCAN,
        ST_DRAIN,
        ST_ROOT,
        ST_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept;
        logic calc_box;
        logic scan_rd;
        logic scan_use;
        logic root_start;
        logic done;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic root_done;
    } t_stat;

endpackage

### rtl/mbbs_ram.sv
module mbbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mbbs_ctrl.sv
module mbbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_vertex,
    input  mbbs_pkg::t_stat i_stat,
    output mbbs_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import mbbs_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:  if (i_start && i_last_vertex) n_state = ST_BOX;
            ST_BOX:   n_state = ST_SCAN;
            ST_SCAN:  if (i_stat.scan_last) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_ROOT;
            ST_ROOT:  if (i_stat.root_done) n_state = ST_DONE;
            ST_DONE:  n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_busy = 1'b0;
                o_cmd.accept = i_start;
            end
            ST_BOX:   o_cmd.calc_box = 1'b1;
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.scan_use = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.scan_use = 1'b1;
                o_cmd.root_start = 1'b1;
            end
            ST_ROOT:  ;
            ST_DONE:  o_cmd.done = 1'b1;
            default:  ;
        endcase
    end

endmodule

### rtl/mbbs_dp.sv
module mbbs_dp #(
    parameter int MAX_VERTICES = mbbs_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mbbs_pkg::t_cmd               i_cmd,
    input  logic signed [31:0]           i_pos_x,
    input  logic signed [31:0]           i_pos_y,
    input  logic signed [31:0]           i_pos_z,
    output mbbs_pkg::t_stat              o_stat,
    output logic signed [31:0]           o_origin_x,
    output logic signed [31:0]           o_origin_y,
    output logic signed [31:0]           o_origin_z,
    output logic [30:0]                  o_extent_x,
    output logic [30:0]                  o_extent_y,
    output logic [30:0]                  o_extent_z,
    output logic [31:0]                  o_sphere_radius,
    output logic                         o_vertex_overflow
);
    import mbbs_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic signed [31:0] r_org [3];
    logic [30:0]        r_ext [3];
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic [CW-1:0]      r_scan;
    logic [SQ_W-1:0]    r_best;
    logic [SQ_W-1:0]    r_sq [3];
    logic               r_sq_v;
    logic               r_rd_v;
    logic [VTX_W-1:0]   w_rdata;
    logic signed [31:0] w_pos [3];
    logic               w_full;
    logic               w_scan_last;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;
    assign w_full = (r_count == CW'(MAX_VERTICES));

    mbbs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && !w_full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Box tracking, store fill and the box result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.done) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= 32'sh7FFFFFFF;
                r_max[a] <= 32'sh80000000;
            end
            r_count <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accept) begin
            for (int a = 0; a < 3; a++) begin
                if (w_pos[a] < r_min[a]) r_min[a] <= w_pos[a];
                if (w_pos[a] > r_max[a]) r_max[a] <= w_pos[a];
            end
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    logic [32:0] w_span [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_span[a] = {r_max[a][31], r_max[a]} - {r_min[a][31], r_min[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_box) begin
            for (int a = 0; a < 3; a++) begin
                r_ext[a] <= w_span[a][31:1];
                r_org[a] <= r_min[a] + $signed({1'b0, w_span[a][31:1]});
            end
        end
    end

    // Scan: read address, then squares, then sum and max.
    // A stored vertex lies inside the box, so each offset is at most 2^31.
    logic [31:0] w_mag [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [32:0] off;
            off = $signed({w_rdata[a*32+31], w_rdata[a*32 +: 32]})
                - $signed({r_org[a][31], r_org[a]});
            w_mag[a] = off[32] ? 32'(-off) : 32'(off);
        end
    end

    assign w_scan_last = (r_scan + 1'b1 >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_rd_v <= 1'b0;
            r_sq_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.scan_rd && (r_scan < r_count);
            r_sq_v <= r_rd_v;
            if (i_cmd.scan_rd) begin
                r_scan <= r_scan + 1'b1;
            end else if (i_cmd.done) begin
                r_scan <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_sq[a] <= {32'd0, w_mag[a]} * {32'd0, w_mag[a]};
        end
        if (i_cmd.calc_box) begin
            r_best <= '0;
        end else if (r_sq_v) begin
            if (r_sq[0] + r_sq[1] + r_sq[2] > r_best) begin
                r_best <= r_sq[0] + r_sq[1] + r_sq[2];
            end
        end
    end

    // Square root of the best, one root bit per step after the scan drains.
    logic [SQ_W-1:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_it;
    logic              r_run;
    logic              r_go;
    logic              r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
            r_run <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_go <= i_cmd.root_start;
            r_fin <= 1'b0;
            // The start passes through r_go so that the last sum reaches r_best first.
            if (r_go) begin
                r_run <= 1'b1;
                r_it <= 5'd0;
                r_root <= '0;
                r_rem <= '0;
            end else if (r_run) begin
                logic [SQ_W+1:0] rem2;
                logic [SQ_W+1:0] trial;
                rem2 = {r_rem, r_best[63 - 2*r_it -: 2]};
                trial = {r_root, 2'b01};
                if (rem2 >= trial) begin
                    r_rem <= SQ_W'(rem2 - trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem <= SQ_W'(rem2);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_it <= r_it + 1'b1;
                if (r_it == 5'd31) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{scan_last: w_scan_last, root_done: r_fin};

    assign o_origin_x = r_org[0];
    assign o_origin_y = r_org[1];
    assign o_origin_z = r_org[2];
    assign o_extent_x = r_ext[0];
    assign o_extent_y = r_ext[1];
    assign o_extent_z = r_ext[2];
    assign o_sphere_radius = r_root;
    assign o_vertex_overflow = r_ovf;

endmodule

### rtl/mesh_bounding_box_and_sphere_top.sv
// Mesh bounding box and bounding sphere.
// Requests: a vertex (i_pos_x/y/z, signed Q16.16, i_last_vertex) is taken
// at a clock edge with start high and busy low, one per cycle while
// loading. Up to MAX_VERTICES vertices are stored; later ones still widen
// the box and set o_vertex_overflow.
// On the request marked last the block goes busy: it computes the box,
// rescans the store with one RAM read per stored vertex, drains the
// distance pipeline, runs the two-bit-a-step square root and then shows
// the result.
// The result shows on the outputs for one cycle with o_valid high; the
// receiver cannot stall. Then the block clears itself for the next mesh.
// Synchronous reset returns the block to loading with an empty store.
module mesh_bounding_box_and_sphere_top #(
    parameter int MAX_VERTICES = mbbs_pkg::MAX_VERTICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_last_vertex,
    output logic               o_valid,
    output logic signed [31:0] o_origin_x,
    output logic signed [31:0] o_origin_y,
    output logic signed [31:0] o_origin_z,
    output logic [30:0]        o_extent_x,
    output logic [30:0]        o_extent_y,
    output logic [30:0]        o_extent_z,
    output logic [31:0]        o_sphere_radius,
    output logic               o_vertex_overflow
);
    import mbbs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mbbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_last_vertex (i_last_vertex),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd),
        .o_busy        (busy)
    );

    mbbs_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .o_stat            (w_stat),
        .o_origin_x        (o_origin_x),
        .o_origin_y        (o_origin_y),
        .o_origin_z        (o_origin_z),
        .o_extent_x        (o_extent_x),
        .o_extent_y        (o_extent_y),
        .o_extent_z        (o_extent_z),
        .o_sphere_radius   (o_sphere_radius),
        .o_vertex_overflow (o_vertex_overflow)
    );

    assign o_valid = w_cmd.done;

    // The result strobe never coincides with taking a request.
    a_no_accept_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    // A result is followed by a return to loading.
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("not idle after result");
    // The result strobe lasts a single cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe too long");

endmodule
